/* rtl/dpc_pkg.sv */
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types and constants for the DAG path counter.
// ----------------------------------------------------------------------------
package dpc_pkg;

  localparam int unsigned CNT_W = 64;  // path count width
  localparam int unsigned NC_W  = 7;   // node_count register width
  localparam int unsigned IDX_W = 6;   // row_index width
  localparam int unsigned ROW_W = 64;  // row_bits width

  localparam logic [NC_W-1:0] NODE_COUNT_RST = 7'd16;
  localparam logic [NC_W-1:0] MIN_NODES      = 7'd2;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_ROWW,
    ST_RD,
    ST_ACC,
    ST_WR,
    ST_DONE
  } dpc_state_e;

endpackage

/* rtl/dpc_in_if.sv */
// ----------------------------------------------------------------------------
// dpc_in_if
// Input channel: one load or compute beat per handshake.
// ----------------------------------------------------------------------------
interface dpc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [dpc_pkg::IDX_W-1:0]   row_index;
  logic [dpc_pkg::ROW_W-1:0]   row_bits;

  modport source (output valid, output operation, output row_index, output row_bits,
                  input ready);
  modport sink   (input valid, input operation, input row_index, input row_bits,
                  output ready);
endinterface

/* rtl/dpc_out_if.sv */
// ----------------------------------------------------------------------------
// dpc_out_if
// Result channel: one path count beat per compute.
// ----------------------------------------------------------------------------
interface dpc_out_if;
  logic                        valid;
  logic                        ready;
  logic [dpc_pkg::CNT_W-1:0]   path_count;
  logic                        overflow;

  modport source (output valid, output path_count, output overflow, input ready);
  modport sink   (input valid, input path_count, input overflow, output ready);
endinterface

/* rtl/dag_path_counter.sv */
// Load beats are accepted back to back while the block is idle. A compute
// beat holds the input channel off until its result is loaded for output;
// one item is worked at a time. The single read port of the count memory
// sets the pace: each predecessor passes a read state, then an accumulate state.
// Reset clears the sequencer and the per-row valid flags, so the adjacency
// store reads as empty at once with no clearing pass; node_count resets to 16.
// ----------------------------------------------------------------------------
// dag_path_counter
// Counts paths from node zero to the last node of a DAG held in memory.
// ----------------------------------------------------------------------------
module dag_path_counter #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [dpc_pkg::NC_W-1:0] cfg_wdata_i,
  dpc_in_if.sink                   in_i,
  dpc_out_if.source                out_o
);

  localparam int unsigned AW = $clog2(MAX_NODES);

  logic                     adj_we;
  logic [AW-1:0]            adj_waddr, adj_raddr;
  logic [MAX_NODES-1:0]     adj_wdata, adj_rdata;
  logic                     cnt_we;
  logic [AW-1:0]            cnt_waddr, cnt_raddr;
  logic [dpc_pkg::CNT_W:0]  cnt_wdata, cnt_rdata;

  dpc_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .adj_we_o    (adj_we),
    .adj_waddr_o (adj_waddr),
    .adj_wdata_o (adj_wdata),
    .adj_raddr_o (adj_raddr),
    .adj_rdata_i (adj_rdata),
    .cnt_we_o    (cnt_we),
    .cnt_waddr_o (cnt_waddr),
    .cnt_wdata_o (cnt_wdata),
    .cnt_raddr_o (cnt_raddr),
    .cnt_rdata_i (cnt_rdata)
  );

  dpc_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  dpc_ram #(
    .WIDTH (dpc_pkg::CNT_W + 1),
    .DEPTH (MAX_NODES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

endmodule

/* rtl/dpc_ram.sv */
// ----------------------------------------------------------------------------
// dpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dpc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dpc_ctrl.sv */
// ----------------------------------------------------------------------------
// dpc_ctrl
// Sequencer: loads adjacency rows, walks nodes and predecessors through the
// two memories and accumulates saturating path counts.
// ----------------------------------------------------------------------------
module dpc_ctrl #(
  parameter int unsigned MAX_NODES = 16,
  localparam int unsigned AW       = $clog2(MAX_NODES)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dpc_pkg::NC_W-1:0]     cfg_wdata_i,
  dpc_in_if.sink                       in_i,
  dpc_out_if.source                    out_o,
  // adjacency memory
  output logic                         adj_we_o,
  output logic [AW-1:0]                adj_waddr_o,
  output logic [MAX_NODES-1:0]         adj_wdata_o,
  output logic [AW-1:0]                adj_raddr_o,
  input  logic [MAX_NODES-1:0]         adj_rdata_i,
  // count memory, top bit is the saturation flag
  output logic                         cnt_we_o,
  output logic [AW-1:0]                cnt_waddr_o,
  output logic [dpc_pkg::CNT_W:0]      cnt_wdata_o,
  output logic [AW-1:0]                cnt_raddr_o,
  input  logic [dpc_pkg::CNT_W:0]      cnt_rdata_i
);

  localparam int unsigned CW = dpc_pkg::CNT_W;

  dpc_pkg::dpc_state_e state_q, state_d;

  logic [dpc_pkg::NC_W-1:0] node_count_q, n_eff;
  logic [AW-1:0]            last;
  logic [AW-1:0]            v_q, v_d, i_q, i_d;
  logic [MAX_NODES-1:0]     row_q, row_d;
  logic [CW-1:0]            acc_q, acc_d;
  logic                     sat_q, sat_d;
  logic [MAX_NODES-1:0]     adj_vld_q;
  logic                     vld_rd_q;
  logic                     out_valid_q, out_valid_d;
  logic [CW-1:0]            out_cnt_q;
  logic                     out_ovf_q;
  logic                     out_load;

  logic                     in_beat, load_beat, load_in_range;
  logic [CW:0]              add_sum;
  logic [dpc_pkg::ROW_W-1:0] row_mask;

  // effective node count clamped to the legal range
  always_comb begin
    n_eff = node_count_q;
    if (n_eff > dpc_pkg::NC_W'(MAX_NODES)) begin
      n_eff = dpc_pkg::NC_W'(MAX_NODES);
    end
    if (n_eff < dpc_pkg::MIN_NODES) begin
      n_eff = dpc_pkg::MIN_NODES;
    end
  end
  assign last = AW'(n_eff - dpc_pkg::NC_W'(1));

  assign in_beat       = in_i.valid && in_i.ready;
  assign load_beat     = in_beat && (in_i.operation == dpc_pkg::OP_LOAD);
  assign load_in_range = {1'b0, in_i.row_index} < dpc_pkg::NC_W'(MAX_NODES);
  assign row_mask      = (dpc_pkg::ROW_W'(1) << in_i.row_index) - dpc_pkg::ROW_W'(1);

  assign add_sum  = {1'b0, acc_q} + {1'b0, cnt_rdata_i[CW-1:0]};
  assign out_load = (state_q == dpc_pkg::ST_DONE) && (!out_valid_q || out_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dpc_pkg::ST_IDLE: begin
        if (in_beat && (in_i.operation == dpc_pkg::OP_COMPUTE)) begin
          state_d = dpc_pkg::ST_INIT;
        end
      end
      dpc_pkg::ST_INIT: state_d = dpc_pkg::ST_ROW;
      dpc_pkg::ST_ROW:  state_d = dpc_pkg::ST_ROWW;
      dpc_pkg::ST_ROWW: state_d = dpc_pkg::ST_RD;
      dpc_pkg::ST_RD:   state_d = dpc_pkg::ST_ACC;
      dpc_pkg::ST_ACC: begin
        state_d = (i_q == v_q - AW'(1)) ? dpc_pkg::ST_WR : dpc_pkg::ST_RD;
      end
      dpc_pkg::ST_WR: begin
        state_d = (v_q == last) ? dpc_pkg::ST_DONE : dpc_pkg::ST_ROW;
      end
      dpc_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = dpc_pkg::ST_IDLE;
        end
      end
      default: state_d = dpc_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    v_d         = v_q;
    i_d         = i_q;
    row_d       = row_q;
    acc_d       = acc_q;
    sat_d       = sat_q;
    adj_we_o    = 1'b0;
    adj_waddr_o = in_i.row_index[AW-1:0];
    adj_wdata_o = in_i.row_bits[MAX_NODES-1:0] & row_mask[MAX_NODES-1:0];
    adj_raddr_o = v_q;
    cnt_we_o    = 1'b0;
    cnt_waddr_o = v_q;
    cnt_wdata_o = {sat_q, acc_q};
    cnt_raddr_o = i_q;
    case (state_q)
      dpc_pkg::ST_IDLE: begin
        adj_we_o = load_beat && load_in_range;
      end
      dpc_pkg::ST_INIT: begin
        // node zero has exactly one path to itself
        cnt_we_o    = 1'b1;
        cnt_waddr_o = '0;
        cnt_wdata_o = {1'b0, CW'(1)};
        v_d         = AW'(1);
      end
      dpc_pkg::ST_ROWW: begin
        row_d = vld_rd_q ? adj_rdata_i : '0;
        acc_d = '0;
        sat_d = 1'b0;
        i_d   = '0;
      end
      dpc_pkg::ST_ACC: begin
        if (row_q[i_q]) begin
          sat_d = sat_q | cnt_rdata_i[CW] | add_sum[CW];
          acc_d = add_sum[CW] ? '1 : add_sum[CW-1:0];
        end
        i_d = i_q + AW'(1);
      end
      dpc_pkg::ST_WR: begin
        cnt_we_o = 1'b1;
        if (v_q != last) begin
          v_d = v_q + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dpc_pkg::ST_IDLE;
      node_count_q <= dpc_pkg::NODE_COUNT_RST;
      adj_vld_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (adj_we_o) begin
        adj_vld_q[adj_waddr_o] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q      <= v_d;
    i_q      <= i_d;
    row_q    <= row_d;
    acc_q    <= acc_d;
    sat_q    <= sat_d;
    vld_rd_q <= adj_vld_q[adj_raddr_o];
    if (out_load) begin
      out_cnt_q <= acc_q;
      out_ovf_q <= sat_q;
    end
  end

  assign in_i.ready       = (state_q == dpc_pkg::ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.path_count = out_cnt_q;
  assign out_o.overflow   = out_ovf_q;

`ifndef NO_ASSERTIONS
  // only predecessors below the current node are visited
  a_pred_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dpc_pkg::ST_ACC) |-> (i_q < v_q))
    else $error("predecessor index not below node");

  // node counter never runs past the target
  a_node_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dpc_pkg::ST_WR) |-> (v_q <= last && v_q != '0))
    else $error("node index out of range");

  // a result beat only appears after the walk has finished
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == dpc_pkg::ST_DONE))
    else $error("result raised outside done state");

  // count memory written only by init or write-back
  a_cnt_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we_o |-> (state_q == dpc_pkg::ST_INIT || state_q == dpc_pkg::ST_WR))
    else $error("unexpected count memory write");
`endif

endmodule

/* sim/dag_path_counter_checker.sv */
// ----------------------------------------------------------------------------
// dag_path_counter_checker
// Watches the load/compute and result channels of the DAG path counter, keeps
// its own copy of the adjacency store and node count, predicts each path count
// and compares it with the result beats in order.
// ----------------------------------------------------------------------------
module dag_path_counter_checker
  import dpc_pkg::*;
#(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [NC_W-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             in_operation_i,
  input  logic [IDX_W-1:0] in_row_index_i,
  input  logic [ROW_W-1:0] in_row_bits_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [CNT_W-1:0] out_path_count_i,
  input  logic             out_overflow_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  typedef struct packed {
    logic [CNT_W-1:0] path_count;
    logic             overflow;
  } path_result_t;

  logic [ROW_W-1:0] edge_rows [MAX_NODES];
  logic [NC_W-1:0]  node_count;
  logic [ROW_W-1:0] below_mask;
  path_result_t     expected_counts [$];
  path_result_t     want;
  int unsigned      fails;
  int unsigned      reported;
  int unsigned      backlog;

  assign fail_count_o = fails;
  assign pending_o    = backlog;

  function automatic path_result_t predict_paths();
    logic [CNT_W-1:0] counts [MAX_NODES];
    logic             sat [MAX_NODES];
    logic [CNT_W:0]   sum;
    int unsigned      nodes;
    int unsigned      last;
    path_result_t     res;
    nodes = node_count;
    if (nodes > MAX_NODES) nodes = MAX_NODES;
    if (nodes < MIN_NODES) nodes = MIN_NODES;
    last = nodes - 1;
    counts[0] = 1;
    sat[0]    = 1'b0;
    for (int v = 1; v <= last; v++) begin
      sum    = '0;
      sat[v] = 1'b0;
      for (int i = 0; i < v; i++) begin
        if (edge_rows[v][i]) begin
          sat[v] = sat[v] | sat[i];
          sum = {1'b0, sum[CNT_W-1:0]} + {1'b0, counts[i]};
          // a carry pins the sum at all ones; landing exactly there does not
          if (sum[CNT_W]) begin
            sum    = {1'b0, {CNT_W{1'b1}}};
            sat[v] = 1'b1;
          end
        end
      end
      counts[v] = sum[CNT_W-1:0];
    end
    res.path_count = counts[last];
    res.overflow   = sat[last];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_NODES; k++) edge_rows[k] = '0;
      node_count = NODE_COUNT_RST;
      expected_counts.delete();
      fails    = 0;
      reported = 0;
      backlog <= 0;
    end else begin
      if (cfg_we_i) node_count = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (in_operation_i == OP_LOAD) begin
          // rows beyond the store are dropped, and a row keeps only lower nodes
          if (in_row_index_i < MAX_NODES) begin
            below_mask = (ROW_W'(1) << in_row_index_i) - 1'b1;
            edge_rows[in_row_index_i] = in_row_bits_i & below_mask;
          end
        end else begin
          expected_counts.insert(expected_counts.size(), predict_paths());
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_counts.size() == 0) begin
          fails++;
          if (reported < 10) begin
            $display("result beat with nothing expected: path_count %0d overflow %0b",
                     out_path_count_i, out_overflow_i);
            reported++;
          end
        end else begin
          want = expected_counts.pop_front();
          if (out_path_count_i !== want.path_count || out_overflow_i !== want.overflow) begin
            fails++;
            if (reported < 10) begin
              $display("mismatch: path_count exp %0d got %0d, overflow exp %0b got %0b",
                       want.path_count, out_path_count_i, want.overflow, out_overflow_i);
              reported++;
            end
          end
        end
      end
      backlog <= expected_counts.size();
    end
  end

endmodule

/* sim/dag_path_counter_test.sv */
// ----------------------------------------------------------------------------
// dag_path_counter_test
// Drives the DAG path counter with directed corner cases and then random
// load/compute phases under several node counts, with random idling on both
// channels; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module dag_path_counter_test;
  import dpc_pkg::*;

  localparam int unsigned NODES_MAX    = 16;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned IDLE_PCT     = 31;
  localparam int unsigned DRAIN_CYCLES = 300;   // beyond one full 16-node compute
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic [NC_W-1:0] cfg_wdata;
  bit              steady;
  int unsigned     items_sent;
  int unsigned     fail_count;
  int unsigned     pending;
  int unsigned     cycles;

  dpc_in_if  path_in ();
  dpc_out_if path_out ();

  dag_path_counter #(.MAX_NODES(NODES_MAX)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (path_in),
    .out_o      (path_out)
  );

  dag_path_counter_checker #(.MAX_NODES(NODES_MAX)) path_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (path_in.valid),
    .in_ready_i      (path_in.ready),
    .in_operation_i  (path_in.operation),
    .in_row_index_i  (path_in.row_index),
    .in_row_bits_i   (path_in.row_bits),
    .out_valid_i     (path_out.valid),
    .out_ready_i     (path_out.ready),
    .out_path_count_i(path_out.path_count),
    .out_overflow_i  (path_out.overflow),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #6 clk = ~clk;

  initial begin
    path_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      path_out.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_beat(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [ROW_W-1:0] bits);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        path_in.valid <= 1'b0;
        @(posedge clk);
      end
    end
    path_in.valid     <= 1'b1;
    path_in.operation <= op;
    path_in.row_index <= idx;
    path_in.row_bits  <= bits;
    do @(posedge clk); while (path_in.ready !== 1'b1);
    if (op == OP_COMPUTE || idx < NODES_MAX) items_sent++;
  endtask

  // hold off until every result is back and the block has surely gone idle
  task automatic drain();
    path_in.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [NC_W-1:0] n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [ROW_W-1:0] pick_row();
    case ($urandom_range(4))
      0:       return '1;
      1:       return '0;
      2:       return {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [NC_W-1:0] pick_nodes();
    case ($urandom_range(9))
      0:       return NC_W'($urandom_range(1));
      1:       return NC_W'($urandom_range(127, 17));
      2:       return MIN_NODES;
      3:       return NC_W'(NODES_MAX);
      default: return NC_W'($urandom_range(NODES_MAX, 3));
    endcase
  endfunction

  task automatic random_load();
    if ($urandom_range(9) == 0)
      send_beat(OP_LOAD, IDX_W'($urandom_range(63, NODES_MAX)), pick_row());
    else
      send_beat(OP_LOAD, IDX_W'($urandom_range(NODES_MAX - 1)), pick_row());
  endtask

  initial begin
    int unsigned segs;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    path_in.valid       <= 1'b0;
    path_in.operation   <= OP_LOAD;
    path_in.row_index   <= '0;
    path_in.row_bits    <= '0;
    steady     = 1'b0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store straight after reset: no path
    send_beat(OP_COMPUTE, '0, '0);
    write_node_count(MIN_NODES);
    send_beat(OP_LOAD, 6'd1, '1);                  // only the edge to node 0 stays
    send_beat(OP_COMPUTE, '0, '0);
    send_beat(OP_LOAD, 6'd0, '1);                  // row 0 can hold no edge
    send_beat(OP_LOAD, 6'd63, '1);                 // rows past the store are dropped
    send_beat(OP_LOAD, IDX_W'(NODES_MAX), '1);
    send_beat(OP_COMPUTE, 6'd63, '1);
    write_node_count(NC_W'(0));                    // too small, acts as two nodes
    send_beat(OP_COMPUTE, '0, '0);
    write_node_count(NC_W'(1));
    send_beat(OP_COMPUTE, '0, '0);
    // too large, acts as the full store; complete graph
    write_node_count(NC_W'(127));
    for (int r = 2; r < NODES_MAX; r++) send_beat(OP_LOAD, IDX_W'(r), '1);
    send_beat(OP_COMPUTE, '0, '0);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady = (items_sent >= 700 && items_sent < 1000);
      if ($urandom_range(3) == 0) write_node_count(pick_nodes());
      segs = $urandom_range(4, 1);
      repeat (segs) begin
        if ($urandom_range(7) == 0) begin
          for (int r = 1; r < NODES_MAX; r++) send_beat(OP_LOAD, IDX_W'(r), pick_row());
        end else begin
          repeat ($urandom_range(10)) random_load();
        end
        send_beat(OP_COMPUTE, IDX_W'($urandom_range(63)), {$urandom, $urandom});
      end
    end
    steady = 1'b0;

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
